/* rtl/core/cmdp_pkg.sv */
// Shared constants, widths and face lookup tables for the cube map pixel core.
package cmdp_pkg;

    // Face codes; basis codes reuse them (axis in the upper bits, sign in bit 0)
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LAYOUT = 2'd0;
    localparam logic [1:0] CFG_RES_X  = 2'd1;
    localparam logic [1:0] CFG_RES_Y  = 2'd2;

    localparam logic [1:0]  LAYOUT_RST = 2'd0;
    localparam logic [12:0] RES_X_RST  = 13'd1024;
    localparam logic [12:0] RES_Y_RST  = 13'd768;

    localparam int PIXEL_FRAC_BITS_DEF = 8;
    localparam int RES_W  = 13;
    localparam int PART_W = 19;
    localparam int DEN_W  = 19;

    // Density datapath widths
    localparam int M2_W   = 31;
    localparam int T_W    = 32;
    localparam int D_W    = 32;
    localparam int FRAC_N = 30;
    localparam int R_W    = 31;
    localparam int SQ_N   = 31;
    localparam int P_W    = D_W + R_W;
    localparam int DENS_LAT = 1 + FRAC_N + SQ_N + 2;

    localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;
    localparam logic [19:0] PIX_MAX  = 20'hFFFFF;
    localparam logic [15:0] DENS_MIN = 16'd2731;
    localparam logic [15:0] DENS_MAX = 16'd14190;

    localparam logic [2:0] TILES_U [4] = '{3'd4, 3'd3, 3'd6, 3'd1};
    localparam logic [2:0] TILES_V [4] = '{3'd3, 3'd4, 3'd1, 3'd6};

    localparam logic [2:0] ORG_U [4][6] = '{
        '{3'd2, 3'd0, 3'd1, 3'd1, 3'd1, 3'd3},
        '{3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd2},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };
    localparam logic [2:0] ORG_V [4][6] = '{
        '{3'd1, 3'd1, 3'd0, 3'd2, 3'd1, 3'd1},
        '{3'd1, 3'd3, 3'd0, 3'd2, 3'd1, 3'd1},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5}
    };
    localparam logic [2:0] BASIS_U [4][6] = '{
        '{FACE_NZ, FACE_PZ, FACE_PX, FACE_PX, FACE_PX, FACE_NX},
        '{FACE_NZ, FACE_NZ, FACE_NZ, FACE_NZ, FACE_PX, FACE_NX},
        '{FACE_NZ, FACE_PZ, FACE_PX, FACE_PX, FACE_PX, FACE_NX},
        '{FACE_NZ, FACE_PZ, FACE_PX, FACE_PX, FACE_PX, FACE_NX}
    };
    localparam logic [2:0] BASIS_V [4][6] = '{
        '{FACE_NY, FACE_NY, FACE_PZ, FACE_NZ, FACE_NY, FACE_NY},
        '{FACE_NY, FACE_PY, FACE_PX, FACE_NX, FACE_NY, FACE_NY},
        '{FACE_NY, FACE_NY, FACE_PZ, FACE_NZ, FACE_NY, FACE_NY},
        '{FACE_NY, FACE_NY, FACE_PZ, FACE_NZ, FACE_NY, FACE_NY}
    };

    function automatic logic [2:0] lut_org_u(input logic [1:0] mode, input logic [2:0] face);
        if (face > FACE_NZ) return 3'd0;
        return ORG_U[mode][face];
    endfunction

    function automatic logic [2:0] lut_org_v(input logic [1:0] mode, input logic [2:0] face);
        if (face > FACE_NZ) return 3'd0;
        return ORG_V[mode][face];
    endfunction

    function automatic logic [2:0] lut_basis_u(input logic [1:0] mode, input logic [2:0] face);
        if (face > FACE_NZ) return FACE_PX;
        return BASIS_U[mode][face];
    endfunction

    function automatic logic [2:0] lut_basis_v(input logic [1:0] mode, input logic [2:0] face);
        if (face > FACE_NZ) return FACE_PX;
        return BASIS_V[mode][face];
    endfunction

endpackage

/* rtl/core/cmdp_pix_div.sv */
// Pipelined restoring divider for the pixel coordinates, one quotient bit per stage.
module cmdp_pix_div #(
    parameter int NW = 41,
    parameter int DW = 19,
    parameter int QB = 21
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [NW-1:0] n_rem [QB];
    logic [DW-1:0] n_den [QB];
    logic [QB-1:0] n_quo [QB];

    // Test one quotient bit per stage, most significant first
    always_comb begin
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quo_in;
        logic [NW-1:0] cand;
        logic          ge;
        for (int k = 0; k < QB; k++) begin
            rem_in = (k == 0) ? i_num : r_rem[(k == 0) ? 0 : k - 1];
            den_in = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            quo_in = (k == 0) ? '0    : r_quo[(k == 0) ? 0 : k - 1];
            cand   = NW'(den_in) << (QB - 1 - k);
            ge     = (rem_in >= cand);
            n_rem[k] = ge ? (rem_in - cand) : rem_in;
            n_den[k] = den_in;
            n_quo[k] = QB'({quo_in, ge});
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

/* rtl/core/cmdp_density.sv */
// Solid-angle density pipeline: fraction divide, square root, product and scale by 1/24.
module cmdp_density (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [cmdp_pkg::T_W-1:0]  i_t,
    input  logic [cmdp_pkg::M2_W-1:0] i_m2,
    output logic [15:0]             o_density
);
    import cmdp_pkg::*;

    // Divide stage: index 0 holds the integer part, 1..FRAC_N one fraction bit each
    logic [M2_W-1:0] r_fr_rem [FRAC_N+1];
    logic [M2_W-1:0] r_fr_m2  [FRAC_N+1];
    logic [D_W-1:0]  r_fr_dq  [FRAC_N+1];
    logic [M2_W-1:0] n_fr_rem [FRAC_N+1];
    logic [D_W-1:0]  n_fr_dq  [FRAC_N+1];

    // Square root stages
    logic [R_W+1:0] r_sq_rem  [SQ_N];
    logic [R_W-1:0] r_sq_root [SQ_N];
    logic [D_W-1:0] r_sq_d    [SQ_N];
    logic [R_W+1:0] n_sq_rem  [SQ_N];
    logic [R_W-1:0] n_sq_root [SQ_N];

    logic [P_W-1:0] r_p;
    logic [15:0]    r_dens;

    // Integer part of denom and fraction bits of the long division
    always_comb begin
        logic [T_W-1:0]  m2x;
        logic [T_W-1:0]  m2x2;
        logic [M2_W:0]   rem2;
        logic            ge;
        m2x  = T_W'(i_m2);
        m2x2 = T_W'({i_m2, 1'b0});
        if (i_t >= m2x2) begin
            n_fr_rem[0] = M2_W'(i_t - m2x2);
            n_fr_dq[0]  = D_W'(3);
        end else if (i_t >= m2x) begin
            n_fr_rem[0] = M2_W'(i_t - m2x);
            n_fr_dq[0]  = D_W'(2);
        end else begin
            n_fr_rem[0] = M2_W'(i_t);
            n_fr_dq[0]  = D_W'(1);
        end
        for (int j = 1; j <= FRAC_N; j++) begin
            rem2 = {r_fr_rem[j-1], 1'b0};
            ge   = (rem2 >= {1'b0, r_fr_m2[j-1]});
            n_fr_rem[j] = M2_W'(ge ? (rem2 - {1'b0, r_fr_m2[j-1]}) : rem2);
            n_fr_dq[j]  = D_W'({r_fr_dq[j-1], ge});
        end
    end

    // Digit-by-digit square root of denom scaled by 2^30, one root bit per stage
    always_comb begin
        logic [R_W+1:0] rem_in;
        logic [R_W-1:0] root_in;
        logic [D_W-1:0] d_in;
        logic [1:0]     pair;
        logic [R_W+3:0] rem_sh;
        logic [R_W+3:0] trial;
        logic           ge;
        for (int s = 0; s < SQ_N; s++) begin
            rem_in  = (s == 0) ? '0 : r_sq_rem[(s == 0) ? 0 : s - 1];
            root_in = (s == 0) ? '0 : r_sq_root[(s == 0) ? 0 : s - 1];
            d_in    = (s == 0) ? r_fr_dq[FRAC_N] : r_sq_d[(s == 0) ? 0 : s - 1];
            if (SQ_N - 1 - s >= 15) pair = d_in[(2 * (SQ_N - 1 - s) - 30) +: 2];
            else pair = 2'b00;
            rem_sh = {rem_in, pair};
            trial  = (R_W + 4)'({root_in, 2'b01});
            ge     = (rem_sh >= trial);
            n_sq_rem[s]  = (R_W + 2)'(ge ? (rem_sh - trial) : rem_sh);
            n_sq_root[s] = R_W'({root_in, ge});
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        logic [19:0] xr;
        logic [16:0] y;
        logic [48:0] prod;
        if (i_en) begin
            r_fr_rem[0] <= n_fr_rem[0];
            r_fr_dq[0]  <= n_fr_dq[0];
            r_fr_m2[0]  <= i_m2;
            for (int j = 1; j <= FRAC_N; j++) begin
                r_fr_rem[j] <= n_fr_rem[j];
                r_fr_dq[j]  <= n_fr_dq[j];
                r_fr_m2[j]  <= r_fr_m2[j-1];
            end
            for (int s = 0; s < SQ_N; s++) begin
                r_sq_rem[s]  <= n_sq_rem[s];
                r_sq_root[s] <= n_sq_root[s];
                r_sq_d[s]    <= (s == 0) ? r_fr_dq[FRAC_N] : r_sq_d[(s == 0) ? 0 : s - 1];
            end
            r_p <= P_W'(r_sq_d[SQ_N-1]) * P_W'(r_sq_root[SQ_N-1]);
            // round and divide by 24: drop 2^44, add half, shift by 3, divide by 3
            xr   = 20'(r_p[P_W-1:44]) + 20'd12;
            y    = 17'(xr >> 3);
            prod = 49'(y) * 49'(RECIP3);
            r_dens <= prod[48:33];
        end
    end

    assign o_density = r_dens;

endmodule

/* rtl/core/cubemap_direction_to_pixel_core.sv */
// Top level of the cube map direction to atlas pixel core.
//
// Usage: directions arrive on the s_axis stream, one transfer per direction; results leave
// on the m_axis stream in the same order, one transfer per direction. Layout and
// resolution are set through the cfg write channel (index 0 layout, 1 res_x, 2 res_y),
// which is always ready; write it only while no direction is in flight.
// The pipeline holds 68 register stages, the first loaded at the input transfer edge;
// m_axis_tvalid rises when a direction reaches the last stage. Throughput is one direction
// per cycle while the receiver does not stall. The depth is set by
// the density path: a 31-stage divider (integer part, then one fraction bit per stage)
// and a 31-stage square root, one bit per stage, plus four front stages and two end stages.
// A zero direction returns invalid in tuser with all data fields zero.
// Reset empties the pipeline and loads layout 0, 1024 x 768.
// When the receiver stalls with a result waiting, the whole pipeline holds and s_axis
// tready drops in the same cycle; nothing is lost or repeated.
module cubemap_direction_to_pixel_core #(
    parameter int PIXEL_FRAC_BITS = cmdp_pkg::PIXEL_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // face[2:0], pixel_u[22:3], pixel_v[42:23],
                                        // density[58:43], zero pad[63:59]
    output logic [0:0]  m_axis_tuser    // invalid[0]
);
    import cmdp_pkg::*;

    localparam int QB    = RES_W + PIXEL_FRAC_BITS;
    localparam int NUM_W = RES_W + PART_W + PIXEL_FRAC_BITS;
    localparam int NW    = NUM_W + 1;
    localparam int FRONT = 4;
    localparam int L     = FRONT + DENS_LAT;
    localparam int DLY   = DENS_LAT - QB;
    localparam int TAG_N = L - 1;

    typedef struct packed {
        logic [2:0]         face;
        logic [15:0]        mag;
        logic signed [16:0] nu;
        logic signed [16:0] nv;
        logic               inv;
    } t_front;

    typedef struct packed {
        logic [2:0] face;
        logic       inv;
    } t_tag;

    function automatic logic signed [16:0] pick(input logic [2:0] code,
                                                input logic [15:0] x,
                                                input logic [15:0] y,
                                                input logic [15:0] z);
        logic [15:0]        c;
        logic signed [16:0] e;
        case (code[2:1])
            AXIS_X:  c = x;
            AXIS_Y:  c = y;
            default: c = z;
        endcase
        e = $signed({c[15], c});
        return code[0] ? -e : e;
    endfunction

    logic [1:0]       r_layout;
    logic [RES_W-1:0] r_res_x;
    logic [RES_W-1:0] r_res_y;
    logic [L-1:0]     r_vld;
    logic             w_en;

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_RST;
            r_res_x  <= RES_X_RST;
            r_res_y  <= RES_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_LAYOUT: r_layout <= i_cfg_data[1:0];
                CFG_RES_X:  r_res_x  <= i_cfg_data;
                CFG_RES_Y:  r_res_y  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Pipeline advances unless a finished result is held by the receiver
    assign w_en          = ~r_vld[L-1] | m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= L'({r_vld[L-2:0], s_axis_tvalid});
    end

    // Stage 1: magnitudes, major axis, face and basis components
    t_front n_a, r_a;
    always_comb begin
        logic [15:0] dx, dy, dz, ax, ay, az;
        logic [1:0]  axis;
        logic        neg;
        dx = s_axis_tdata[15:0];
        dy = s_axis_tdata[31:16];
        dz = s_axis_tdata[47:32];
        ax = dx[15] ? (~dx + 16'd1) : dx;
        ay = dy[15] ? (~dy + 16'd1) : dy;
        az = dz[15] ? (~dz + 16'd1) : dz;
        if (ax >= ay && ax >= az) begin
            axis = AXIS_X; neg = dx[15]; n_a.mag = ax;
        end else if (ay >= az) begin
            axis = AXIS_Y; neg = dy[15]; n_a.mag = ay;
        end else begin
            axis = AXIS_Z; neg = dz[15]; n_a.mag = az;
        end
        n_a.face = {axis, neg};
        n_a.nu   = pick(lut_basis_u(r_layout, n_a.face), dx, dy, dz);
        n_a.nv   = pick(lut_basis_v(r_layout, n_a.face), dx, dy, dz);
        n_a.inv  = (ax == 16'd0) && (ay == 16'd0) && (az == 16'd0);
    end

    // Stage 2: tile-relative numerators, denominators and squares
    logic [PART_W-1:0] r_b_part_u, r_b_part_v;
    logic [DEN_W-1:0]  r_b_den_u, r_b_den_v;
    logic [M2_W-1:0]   r_b_m2, r_b_nusq, r_b_nvsq;
    // Stage 3: resolution scaling
    logic [NUM_W-1:0]  r_c_num_u, r_c_num_v;
    logic [DEN_W-1:0]  r_c_den_u, r_c_den_v;
    logic [T_W-1:0]    r_c_t;
    logic [M2_W-1:0]   r_c_m2;
    // Stage 4: rounding offset
    logic [NW-1:0]     r_d_num_u, r_d_num_v;
    logic [DEN_W-1:0]  r_d_den_u, r_d_den_v;
    logic [T_W-1:0]    r_d_t;
    logic [M2_W-1:0]   r_d_m2;

    always_ff @(posedge i_clk) begin
        logic [16:0] two_m, npm_u, npm_v;
        if (w_en) begin
            r_a <= n_a;
            two_m = {r_a.mag, 1'b0};
            npm_u = 17'(r_a.nu) + {1'b0, r_a.mag};
            npm_v = 17'(r_a.nv) + {1'b0, r_a.mag};
            r_b_part_u <= PART_W'(lut_org_u(r_layout, r_a.face)) * PART_W'(two_m)
                          + PART_W'(npm_u);
            r_b_part_v <= PART_W'(lut_org_v(r_layout, r_a.face)) * PART_W'(two_m)
                          + PART_W'(npm_v);
            r_b_den_u  <= DEN_W'(TILES_U[r_layout]) * DEN_W'(two_m);
            r_b_den_v  <= DEN_W'(TILES_V[r_layout]) * DEN_W'(two_m);
            r_b_m2     <= M2_W'(r_a.mag) * M2_W'(r_a.mag);
            r_b_nusq   <= M2_W'(r_a.nu) * M2_W'(r_a.nu);
            r_b_nvsq   <= M2_W'(r_a.nv) * M2_W'(r_a.nv);

            r_c_num_u <= NUM_W'(r_res_x) * (NUM_W'(r_b_part_u) << PIXEL_FRAC_BITS);
            r_c_num_v <= NUM_W'(r_res_y) * (NUM_W'(r_b_part_v) << PIXEL_FRAC_BITS);
            r_c_den_u <= r_b_den_u;
            r_c_den_v <= r_b_den_v;
            r_c_t     <= T_W'(r_b_nusq) + T_W'(r_b_nvsq);
            r_c_m2    <= r_b_m2;

            r_d_num_u <= NW'(r_c_num_u) + NW'(r_c_den_u >> 1);
            r_d_num_v <= NW'(r_c_num_v) + NW'(r_c_den_v >> 1);
            r_d_den_u <= r_c_den_u;
            r_d_den_v <= r_c_den_v;
            r_d_t     <= r_c_t;
            r_d_m2    <= r_c_m2;
        end
    end

    // Pixel dividers and density pipeline
    logic [QB-1:0] w_quo_u, w_quo_v;
    logic [15:0]   w_density;

    cmdp_pix_div #(.NW(NW), .DW(DEN_W), .QB(QB)) u_div_u (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_d_num_u), .i_den (r_d_den_u),
        .o_quo (w_quo_u)
    );
    cmdp_pix_div #(.NW(NW), .DW(DEN_W), .QB(QB)) u_div_v (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_d_num_v), .i_den (r_d_den_v),
        .o_quo (w_quo_v)
    );
    cmdp_density u_density (
        .i_clk (i_clk), .i_en (w_en), .i_t (r_d_t), .i_m2 (r_d_m2),
        .o_density (w_density)
    );

    // Saturate pixel coordinates and align them and the tag with the density
    logic [19:0] w_sat_u, w_sat_v;
    logic [19:0] r_dl_u [DLY];
    logic [19:0] r_dl_v [DLY];
    t_tag        r_dl_tag [TAG_N];

    assign w_sat_u = (32'(w_quo_u) > 32'(PIX_MAX)) ? PIX_MAX : 20'(w_quo_u);
    assign w_sat_v = (32'(w_quo_v) > 32'(PIX_MAX)) ? PIX_MAX : 20'(w_quo_v);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_u[0]   <= w_sat_u;
            r_dl_v[0]   <= w_sat_v;
            r_dl_tag[0] <= '{face: r_a.face, inv: r_a.inv};
            for (int i = 1; i < DLY; i++) begin
                r_dl_u[i] <= r_dl_u[i-1];
                r_dl_v[i] <= r_dl_v[i-1];
            end
            for (int i = 1; i < TAG_N; i++) r_dl_tag[i] <= r_dl_tag[i-1];
        end
    end

    // Output, with all data zeroed for a zero direction
    t_tag w_tag;
    assign w_tag         = r_dl_tag[TAG_N-1];
    assign m_axis_tvalid = r_vld[L-1];
    assign m_axis_tuser  = w_tag.inv;
    assign m_axis_tdata  = w_tag.inv ? 64'd0 :
                           {5'd0, w_density, r_dl_v[DLY-1], r_dl_u[DLY-1], w_tag.face};

    // Checks
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("zero direction result carries data");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[2:0] <= FACE_NZ)
        else $error("face code out of range");

    a_dens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[58:43] >= DENS_MIN && m_axis_tdata[58:43] <= DENS_MAX)
        else $error("density outside the range of denom 1..3");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted direction did not enter the pipeline");

endmodule
